// File: sv/aoc_pkg.sv
// Package with the shared types and constants of the ARGB source-over compositor.
package aoc_pkg;

	// Full-scale value of one 8-bit channel.
	localparam int CH_MAX = 255;

	// Number of color channels and of divider lanes (alpha plus three colors).
	localparam int NCH   = 3;
	localparam int LANES = 4;

	// Lane numbers inside the divider.
	localparam int LANE_A = 0;
	localparam int LANE_R = 1;
	localparam int LANE_G = 2;
	localparam int LANE_B = 3;

	// Operand widths: the dividend reaches 511 * 65025, the divisor 2 * 65025.
	localparam int CH_W  = 8;
	localparam int PRD_W = 16;
	localparam int NUM_W = 25;
	localparam int DVS_W = 17;
	localparam int Q_W   = 8;

	// The divider resolves two quotient bits per stage.
	localparam int BITS_PER_STG = 2;
	localparam int DIV_STG      = Q_W / BITS_PER_STG;

	// Two operand stages, then the divider stages.
	localparam int LATENCY = 2 + DIV_STG;

	// Value of the mode input that selects blending over an opaque pixel.
	localparam logic MODE_OPAQUE = 1'b1;

	// How a pixel pair is resolved.
	typedef enum logic [1:0] {
		SEL_BLEND,
		SEL_OPAQUE,
		SEL_SRC,
		SEL_DST
	} sel_t;

	// One divider operand pair: the quotient is floor(num / dvs).
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DVS_W-1:0] dvs;
	} lane_t;

endpackage

// File: sv/aoc_prep.sv
// Two-stage operand preparation: products, blend denominator and divider operands.
module aoc_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic                          mode,
	input  logic [aoc_pkg::CH_W-1:0]      src_a,
	input  logic [aoc_pkg::CH_W-1:0]      src_r,
	input  logic [aoc_pkg::CH_W-1:0]      src_g,
	input  logic [aoc_pkg::CH_W-1:0]      src_b,
	input  logic [aoc_pkg::CH_W-1:0]      dst_a,
	input  logic [aoc_pkg::CH_W-1:0]      dst_r,
	input  logic [aoc_pkg::CH_W-1:0]      dst_g,
	input  logic [aoc_pkg::CH_W-1:0]      dst_b,
	output logic                          vld_s2,
	output aoc_pkg::lane_t                op_s2 [aoc_pkg::LANES]
);

	localparam logic [aoc_pkg::CH_W-1:0] CMAX = aoc_pkg::CH_W'(aoc_pkg::CH_MAX);

	logic [aoc_pkg::CH_W-1:0] sc [aoc_pkg::NCH];
	logic [aoc_pkg::CH_W-1:0] dc [aoc_pkg::NCH];
	logic [aoc_pkg::CH_W-1:0] inv_sa;
	aoc_pkg::sel_t            sel_d;

	logic                      vld_s1;
	aoc_pkg::sel_t             sel_s1;
	logic [aoc_pkg::CH_W-1:0]  sa_s1;
	logic [aoc_pkg::CH_W-1:0]  da_s1;
	logic [aoc_pkg::CH_W-1:0]  sc_s1   [aoc_pkg::NCH];
	logic [aoc_pkg::CH_W-1:0]  dc_s1   [aoc_pkg::NCH];
	logic [aoc_pkg::PRD_W-1:0] psrc_s1 [aoc_pkg::NCH];
	logic [aoc_pkg::PRD_W-1:0] pdst_s1 [aoc_pkg::NCH];
	logic [aoc_pkg::PRD_W-1:0] pda_s1;
	logic [aoc_pkg::PRD_W-1:0] den_s1;

	aoc_pkg::lane_t op_d [aoc_pkg::LANES];

	assign sc[0]  = src_r;
	assign sc[1]  = src_g;
	assign sc[2]  = src_b;
	assign dc[0]  = dst_r;
	assign dc[1]  = dst_g;
	assign dc[2]  = dst_b;
	assign inv_sa = CMAX - src_a;

	// Opaque mode selects the opaque blend; otherwise opaque or transparent operands short-cut the blend; order decides.
	always_comb begin
		priority if (mode == aoc_pkg::MODE_OPAQUE) begin
			sel_d = aoc_pkg::SEL_OPAQUE;
		end else if (src_a == CMAX) begin
			sel_d = aoc_pkg::SEL_SRC;
		end else if (src_a == '0) begin
			sel_d = aoc_pkg::SEL_DST;
		end else if (dst_a == '0) begin
			sel_d = aoc_pkg::SEL_SRC;
		end else begin
			sel_d = aoc_pkg::SEL_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= sel_d;
		sa_s1  <= src_a;
		da_s1  <= dst_a;
		pda_s1 <= aoc_pkg::PRD_W'(inv_sa * dst_a);
		// The denominator 255*sa + (255-sa)*da never exceeds 65025.
		den_s1 <= aoc_pkg::PRD_W'(CMAX * src_a) + aoc_pkg::PRD_W'(inv_sa * dst_a);
		for (int c = 0; c < aoc_pkg::NCH; c++) begin
			sc_s1[c]   <= sc[c];
			dc_s1[c]   <= dc[c];
			psrc_s1[c] <= aoc_pkg::PRD_W'(src_a * sc[c]);
			pdst_s1[c] <= aoc_pkg::PRD_W'(inv_sa * dc[c]);
		end
	end

	// Dividend and divisor for every lane.
	always_comb begin
		logic [aoc_pkg::NUM_W-1:0] num;
		num = '0;
		for (int l = 0; l < aoc_pkg::LANES; l++) begin
			op_d[l] = '0;
		end
		unique case (sel_s1)
			aoc_pkg::SEL_BLEND: begin
				op_d[aoc_pkg::LANE_A].num = (aoc_pkg::NUM_W'(den_s1) << 1)
					+ aoc_pkg::NUM_W'(aoc_pkg::CH_MAX);
				op_d[aoc_pkg::LANE_A].dvs = aoc_pkg::DVS_W'(2 * aoc_pkg::CH_MAX);
				for (int c = 0; c < aoc_pkg::NCH; c++) begin
					num = (aoc_pkg::NUM_W'(psrc_s1[c]) << aoc_pkg::CH_W)
						- aoc_pkg::NUM_W'(psrc_s1[c])
						+ aoc_pkg::NUM_W'(pda_s1 * dc_s1[c]);
					op_d[c + 1].num = (num << 1) + aoc_pkg::NUM_W'(den_s1);
					op_d[c + 1].dvs = {den_s1, 1'b0};
				end
			end
			aoc_pkg::SEL_OPAQUE: begin
				op_d[aoc_pkg::LANE_A].num = aoc_pkg::NUM_W'(aoc_pkg::CH_MAX);
				op_d[aoc_pkg::LANE_A].dvs = aoc_pkg::DVS_W'(1);
				for (int c = 0; c < aoc_pkg::NCH; c++) begin
					op_d[c + 1].num = aoc_pkg::NUM_W'(psrc_s1[c])
						+ aoc_pkg::NUM_W'(pdst_s1[c]);
					op_d[c + 1].dvs = aoc_pkg::DVS_W'(aoc_pkg::CH_MAX);
				end
			end
			aoc_pkg::SEL_SRC: begin
				op_d[aoc_pkg::LANE_A].num = aoc_pkg::NUM_W'(sa_s1);
				op_d[aoc_pkg::LANE_A].dvs = aoc_pkg::DVS_W'(1);
				for (int c = 0; c < aoc_pkg::NCH; c++) begin
					op_d[c + 1].num = aoc_pkg::NUM_W'(sc_s1[c]);
					op_d[c + 1].dvs = aoc_pkg::DVS_W'(1);
				end
			end
			aoc_pkg::SEL_DST: begin
				op_d[aoc_pkg::LANE_A].num = aoc_pkg::NUM_W'(da_s1);
				op_d[aoc_pkg::LANE_A].dvs = aoc_pkg::DVS_W'(1);
				for (int c = 0; c < aoc_pkg::NCH; c++) begin
					op_d[c + 1].num = aoc_pkg::NUM_W'(dc_s1[c]);
					op_d[c + 1].dvs = aoc_pkg::DVS_W'(1);
				end
			end
			default: begin
				for (int l = 0; l < aoc_pkg::LANES; l++) begin
					op_d[l] = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < aoc_pkg::LANES; l++) begin
			op_s2[l] <= op_d[l];
		end
	end

endmodule

// File: sv/aoc_div.sv
// Pipelined restoring divider, four lanes, two quotient bits per stage.
module aoc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  aoc_pkg::lane_t           in_op  [aoc_pkg::LANES],
	output logic                     out_vld,
	output logic [aoc_pkg::Q_W-1:0]  out_quo [aoc_pkg::LANES]
);

	// Stage registers; the num field holds the running remainder.
	logic [aoc_pkg::DIV_STG-1:0] vld_s;
	aoc_pkg::lane_t              op_s  [aoc_pkg::DIV_STG][aoc_pkg::LANES];
	logic [aoc_pkg::Q_W-1:0]     quo_s [aoc_pkg::DIV_STG][aoc_pkg::LANES];

	for (genvar g = 0; g < aoc_pkg::DIV_STG; g++) begin : g_stg
		logic                    vld_d;
		aoc_pkg::lane_t          op_d  [aoc_pkg::LANES];
		logic [aoc_pkg::Q_W-1:0] quo_d [aoc_pkg::LANES];
		aoc_pkg::lane_t          op_n  [aoc_pkg::LANES];
		logic [aoc_pkg::Q_W-1:0] quo_n [aoc_pkg::LANES];

		if (g == 0) begin : g_first
			assign vld_d = in_vld;
			for (genvar l = 0; l < aoc_pkg::LANES; l++) begin : g_lane
				assign op_d[l]  = in_op[l];
				assign quo_d[l] = '0;
			end
		end else begin : g_next
			assign vld_d = vld_s[g-1];
			for (genvar l = 0; l < aoc_pkg::LANES; l++) begin : g_lane
				assign op_d[l]  = op_s[g-1][l];
				assign quo_d[l] = quo_s[g-1][l];
			end
		end

		// The quotient is known to stay below 256, so the top bit is tried first.
		always_comb begin
			logic [aoc_pkg::NUM_W-1:0] rem;
			logic [aoc_pkg::NUM_W-1:0] sh;
			logic [aoc_pkg::Q_W-1:0]   q;
			for (int l = 0; l < aoc_pkg::LANES; l++) begin
				rem = op_d[l].num;
				q   = quo_d[l];
				for (int j = 0; j < aoc_pkg::BITS_PER_STG; j++) begin
					sh = aoc_pkg::NUM_W'(op_d[l].dvs)
						<< (aoc_pkg::Q_W - 1 - aoc_pkg::BITS_PER_STG * g - j);
					if (rem >= sh) begin
						rem = rem - sh;
						q[aoc_pkg::Q_W - 1 - aoc_pkg::BITS_PER_STG * g - j] = 1'b1;
					end
				end
				op_n[l].num = rem;
				op_n[l].dvs = op_d[l].dvs;
				quo_n[l]    = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < aoc_pkg::LANES; l++) begin
				op_s[g][l]  <= op_n[l];
				quo_s[g][l] <= quo_n[l];
			end
		end
	end

	assign out_vld = vld_s[aoc_pkg::DIV_STG-1];
	for (genvar l = 0; l < aoc_pkg::LANES; l++) begin : g_out
		assign out_quo[l] = quo_s[aoc_pkg::DIV_STG-1][l];
	end

endmodule

// File: sv/argb_over_compositor_top.sv
// Top level of the ARGB source-over compositor: operand stages and the divider pipeline.
//
// The block composites one non-premultiplied ARGB8888 source pixel over one
// destination pixel per request. A request is taken at a rising clock edge at
// which start is high and busy is low. The mode input picks blending over a
// translucent ARGB destination or over an opaque pixel.
//
// The pipeline never stalls, so busy stays low and a new request may be given
// in every cycle: the sustained rate is one pixel per clock. Each result shows
// on out_a, out_r, out_g and out_b for exactly one cycle, with done high. The
// pipeline has two operand stages (products, then blend numerators and
// denominators) and four divider stages, each resolving two bits of the 8-bit
// quotient for all four channels at once. Simple cases (opaque or transparent
// operands) pass through the same divider with a divisor of one, so every
// result has the same latency and results come out in request order.
//
// Reset clears only the valid bits of the pipeline; no result appears until a
// request has been taken. The receiver cannot stall, so there is no back
// pressure: every result must be taken in the cycle it is shown.
module argb_over_compositor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       mode,
	input  logic [7:0] src_a,
	input  logic [7:0] src_r,
	input  logic [7:0] src_g,
	input  logic [7:0] src_b,
	input  logic [7:0] dst_a,
	input  logic [7:0] dst_r,
	input  logic [7:0] dst_g,
	input  logic [7:0] dst_b,
	output logic       done,
	output logic [7:0] out_a,
	output logic [7:0] out_r,
	output logic [7:0] out_g,
	output logic [7:0] out_b
);

	logic                    acc;
	logic                    vld_s2;
	aoc_pkg::lane_t          op_s2 [aoc_pkg::LANES];
	logic [aoc_pkg::Q_W-1:0] quo   [aoc_pkg::LANES];

	// Every stage moves forward in every cycle, so a request is never refused.
	assign busy = 1'b0;
	assign acc  = start && !busy;

	aoc_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (acc),
		.mode   (mode),
		.src_a  (src_a),
		.src_r  (src_r),
		.src_g  (src_g),
		.src_b  (src_b),
		.dst_a  (dst_a),
		.dst_r  (dst_r),
		.dst_g  (dst_g),
		.dst_b  (dst_b),
		.vld_s2 (vld_s2),
		.op_s2  (op_s2)
	);

	aoc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_op   (op_s2),
		.out_vld (done),
		.out_quo (quo)
	);

	// The divider's last stage registers drive the result ports directly.
	assign out_a = quo[aoc_pkg::LANE_A];
	assign out_r = quo[aoc_pkg::LANE_R];
	assign out_g = quo[aoc_pkg::LANE_G];
	assign out_b = quo[aoc_pkg::LANE_B];

	// Every request gives exactly one result.
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##(aoc_pkg::LATENCY) done)
		else $error("request did not produce a result at the expected cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |-> ##(aoc_pkg::LATENCY) !done)
		else $error("result strobe without a matching request");

	// Blending over an opaque pixel always yields an opaque result.
	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode == aoc_pkg::MODE_OPAQUE) |-> ##(aoc_pkg::LATENCY) (out_a == 8'hFF))
		else $error("opaque blend gave a translucent alpha");

	// An opaque source passes straight through in translucent mode.
	a_src_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode != aoc_pkg::MODE_OPAQUE && src_a == 8'hFF)
		|-> ##(aoc_pkg::LATENCY)
		(out_a == 8'hFF && out_r == $past(src_r, aoc_pkg::LATENCY)))
		else $error("opaque source was not passed through");

endmodule
